/* rtl/atdq_pkg.sv */
// Package for the averaged threshold drop queue.
// Holds payload structs, status codes and default sizes; no dependencies.
package atdq_pkg;

   // Default ring capacity and register reset value
   localparam int QUEUE_DEPTH_DEF = 8;
   localparam int THRESH_W        = 4;
   localparam int LEN_W           = 4;
   localparam logic [THRESH_W-1:0] THRESH_RESET = 4'd7;

   // Request command codes
   localparam logic CMD_ENQUEUE = 1'b0;
   localparam logic CMD_DEQUEUE = 1'b1;

   typedef enum logic [1:0] {
      ST_QUEUED    = 2'd0,
      ST_DROPPED   = 2'd1,
      ST_DELIVERED = 2'd2,
      ST_EMPTY     = 2'd3
   } status_type;

   typedef struct packed {
      logic        cmd;
      logic [15:0] packet_number;
      logic [7:0]  source_address;
      logic [7:0]  destination_address;
   } req_type;

   typedef struct packed {
      status_type       status;
      logic [15:0]      out_packet_number;
      logic [7:0]       out_source_address;
      logic [7:0]       out_destination_address;
      logic             congestion_bit;
      logic [LEN_W-1:0] average_length_out;
      logic [LEN_W-1:0] queue_length_out;
   } rsp_type;

   // One stored packet
   typedef struct packed {
      logic [15:0] num;
      logic [7:0]  src;
      logic [7:0]  dst;
   } packet_type;

   // Classified operation handed from front to back
   typedef struct packed {
      status_type       status;
      packet_type       packet;
      logic             cong;
      logic [LEN_W-1:0] avg;
      logic [LEN_W-1:0] len;
   } op_type;

endpackage

/* rtl/atdq_front.sv */
// Front end: accepts requests, keeps count, average and ring pointers,
// and classifies each request into a memory operation. Uses atdq_pkg.
module atdq_front import atdq_pkg::*; #(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
   localparam int AW = $clog2(QUEUE_DEPTH),
   localparam int CW = $clog2(QUEUE_DEPTH + 1)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                q_full,
   input  req_type             req_data,
   input  logic                csr_wr_en,
   input  logic [THRESH_W-1:0] csr_wr_data,
   output logic                push,
   output op_type              op,
   output logic [AW-1:0]       op_addr
);

   localparam int CMPW = (CW > THRESH_W) ? CW : THRESH_W;

   logic [CW-1:0]       count_ff, count_in;
   logic [CW-1:0]       avg_ff, avg_in;
   logic [AW-1:0]       head_ff, head_in;
   logic [AW-1:0]       tail_ff, tail_in;
   logic [THRESH_W-1:0] thresh_ff;

   logic [CW:0]   raised, dec, sum_enq, sum_deq;
   logic [CW-1:0] avg_enq, avg_deq;
   logic          full, empty, cong;
   packet_type    pkt;

   assign push = req_valid && !q_full;

   // Average candidates for enqueue and dequeue
   always_comb begin
      raised  = {1'b0, count_ff} + 1'b1;
      dec     = {1'b0, count_ff} - 1'b1;
      sum_enq = {1'b0, avg_ff} + raised;
      sum_deq = {1'b0, avg_ff} + dec;
      avg_enq = sum_enq[CW:1];
      avg_deq = sum_deq[CW:1];
      full    = (count_ff == CW'(QUEUE_DEPTH));
      empty   = (count_ff == '0);
      cong    = CMPW'(avg_enq) >= CMPW'(thresh_ff);
      pkt.num = req_data.packet_number;
      pkt.src = req_data.source_address;
      pkt.dst = req_data.destination_address;
   end

   // Classify the request and compute next state
   always_comb begin
      count_in   = count_ff;
      avg_in     = avg_ff;
      head_in    = head_ff;
      tail_in    = tail_ff;
      op.status  = ST_EMPTY;
      op.packet  = '0;
      op.cong    = 1'b0;
      op_addr    = head_ff;
      if (req_data.cmd == CMD_ENQUEUE) begin
         avg_in    = avg_enq;
         op.packet = pkt;
         op.cong   = cong;
         op_addr   = tail_ff;
         if (cong || full) begin
            op.status = ST_DROPPED;
         end else begin
            op.status = ST_QUEUED;
            count_in  = raised[CW-1:0];
            tail_in   = (tail_ff == AW'(QUEUE_DEPTH - 1)) ? '0 : tail_ff + 1'b1;
         end
      end else if (!empty) begin
         op.status = ST_DELIVERED;
         count_in  = dec[CW-1:0];
         avg_in    = avg_deq;
         head_in   = (head_ff == AW'(QUEUE_DEPTH - 1)) ? '0 : head_ff + 1'b1;
      end
      op.avg = LEN_W'(avg_in);
      op.len = LEN_W'(count_in);
   end

   // Advance state on each accepted request
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         avg_ff   <= '0;
         head_ff  <= '0;
         tail_ff  <= '0;
      end else if (push) begin
         count_ff <= count_in;
         avg_ff   <= avg_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
      end
   end

   // Threshold register
   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= THRESH_RESET;
      end else if (csr_wr_en) begin
         thresh_ff <= csr_wr_data;
      end
   end

endmodule

/* rtl/atdq_cmd_queue.sv */
// Two-entry operation queue between front and back ends.
// Generic width; uses atdq_pkg only for the common import style.
module atdq_cmd_queue import atdq_pkg::*; #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   input  logic             pop,
   output logic             full,
   output logic             not_empty,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] slot_ff [2];
   logic             wptr_ff, rptr_ff;
   logic [1:0]       fill_ff;

   assign full      = (fill_ff == 2'd2);
   assign not_empty = (fill_ff != 2'd0);
   assign rdata     = slot_ff[rptr_ff];

   // Store entries
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wptr_ff] <= wdata;
      end
   end

   // Advance pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         fill_ff <= 2'd0;
      end else begin
         if (push) wptr_ff <= ~wptr_ff;
         if (pop)  rptr_ff <= ~rptr_ff;
         fill_ff <= fill_ff + {1'b0, push} - {1'b0, pop};
      end
   end

endmodule

/* rtl/atdq_back.sv */
// Back end: executes operations against the packet ring memory and holds
// the response register. Uses atdq_pkg.
module atdq_back import atdq_pkg::*; #(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
   localparam int AW = $clog2(QUEUE_DEPTH)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          op_valid,
   input  op_type        op,
   input  logic [AW-1:0] op_addr,
   output logic          pop,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output rsp_type       rsp_data
);

   packet_type mem [QUEUE_DEPTH];
   packet_type rd_ff;
   op_type     pend_ff;
   logic       pend_valid_ff;
   packet_type pkt;

   // Take the next operation when the response slot frees up
   assign pop       = op_valid && (!pend_valid_ff || !rsp_stall);
   assign rsp_valid = pend_valid_ff;

   // Ring memory: write on queue, registered read on deliver
   always_ff @(posedge clock) begin
      if (pop && op.status == ST_QUEUED) begin
         mem[op_addr] <= op.packet;
      end
      if (pop && op.status == ST_DELIVERED) begin
         rd_ff <= mem[op_addr];
      end
   end

   // Hold the pending operation
   always_ff @(posedge clock) begin
      if (pop) begin
         pend_ff <= op;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
      end else if (pop) begin
         pend_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         pend_valid_ff <= 1'b0;
      end
   end

   // Assemble the response
   always_comb begin
      pkt = (pend_ff.status == ST_DELIVERED) ? rd_ff : pend_ff.packet;
      rsp_data.status                  = pend_ff.status;
      rsp_data.out_packet_number       = pkt.num;
      rsp_data.out_source_address      = pkt.src;
      rsp_data.out_destination_address = pkt.dst;
      rsp_data.congestion_bit          = pend_ff.cong;
      rsp_data.average_length_out      = pend_ff.avg;
      rsp_data.queue_length_out        = pend_ff.len;
   end

endmodule

/* rtl/averaged_threshold_drop_queue_core.sv */
// Averaged threshold drop queue: packet ring with congestion drop.
// A request accepted passes through the operation queue and the back end's pending register
// before its response is valid. Throughput: one request per cycle while rsp_stall stays low.
// Reset (synchronous, active high): empty ring, zero average, threshold 7;
// the ring memory is not cleared.
module averaged_threshold_drop_queue_core import atdq_pkg::*; #(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  req_type             req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output rsp_type             rsp_data,
   input  logic                csr_wr_en,
   input  logic [THRESH_W-1:0] csr_wr_data
);

   localparam int AW = $clog2(QUEUE_DEPTH);
   localparam int QW = AW + $bits(op_type);

   logic          push, pop, q_full, q_not_empty;
   op_type        f_op, b_op;
   logic [AW-1:0] f_addr, b_addr;
   logic [QW-1:0] q_rdata;

   assign req_stall = q_full;

   atdq_front #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .q_full      (q_full),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .push        (push),
      .op          (f_op),
      .op_addr     (f_addr)
   );

   atdq_cmd_queue #(.WIDTH(QW)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .wdata     ({f_addr, f_op}),
      .pop       (pop),
      .full      (q_full),
      .not_empty (q_not_empty),
      .rdata     (q_rdata)
   );

   assign b_addr = q_rdata[QW-1 -: AW];
   assign b_op   = q_rdata[$bits(op_type)-1:0];

   atdq_back #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_back (
      .clock     (clock),
      .reset     (reset),
      .op_valid  (q_not_empty),
      .op        (b_op),
      .op_addr   (b_addr),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

/* test/tb.sv */
// Self-checking testbench for averaged_threshold_drop_queue_core.
// Uses atdq_pkg for payload types and codes; drives requests against an in-bench
// ring queue predictor.
module tb;
   import atdq_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH       = QUEUE_DEPTH_DEF;
   localparam int PHASE_REQS  = 175;
   localparam int STALL_LIMIT = 1000;

   typedef struct packed {
      req_type req;
      logic    typed;
      rsp_type want;
   } plan_row_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   req_type             req_data = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   rsp_type             rsp_data;
   logic                csr_wr_en = 1'b0;
   logic [THRESH_W-1:0] csr_wr_data = '0;

   // Side data that travels with the request being driven
   logic    typed_has = 1'b0;
   rsp_type typed_rsp = '0;

   // Predictor state
   packet_type ring_copy [DEPTH];
   int         ring_head;
   int         ring_tail;
   int         ring_count;
   int         avg_len;
   int         drop_thresh;

   rsp_type      pending_rsp [$];
   plan_row_type directed_plan [$];
   int           req_accepted = 0;
   int           mismatches = 0;
   int           quiet_cycles = 0;
   bit           gaps_on = 1'b1;
   bit           stall_on = 1'b1;

   averaged_threshold_drop_queue_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Advance the queue model by one request and return the response it causes
   function automatic rsp_type predict_queue_op(req_type r);
      rsp_type o;
      int      raised;
      logic    congested;
      o = '0;
      if (r.cmd == CMD_ENQUEUE) begin
         raised = ring_count + 1;
         avg_len = (avg_len + raised) >> 1;
         congested = (avg_len >= drop_thresh);
         o.out_packet_number = r.packet_number;
         o.out_source_address = r.source_address;
         o.out_destination_address = r.destination_address;
         o.congestion_bit = congested;
         if (congested || ring_count >= DEPTH) begin
            o.status = ST_DROPPED;
         end else begin
            ring_copy[ring_tail] = '{r.packet_number, r.source_address,
                                     r.destination_address};
            ring_tail = (ring_tail + 1) % DEPTH;
            ring_count = raised;
            o.status = ST_QUEUED;
         end
      end else if (ring_count == 0) begin
         o.status = ST_EMPTY;
      end else begin
         o.out_packet_number = ring_copy[ring_head].num;
         o.out_source_address = ring_copy[ring_head].src;
         o.out_destination_address = ring_copy[ring_head].dst;
         ring_head = (ring_head + 1) % DEPTH;
         ring_count = ring_count - 1;
         avg_len = (avg_len + ring_count) >> 1;
         o.status = ST_DELIVERED;
      end
      o.average_length_out = LEN_W'(avg_len);
      o.queue_length_out = LEN_W'(ring_count);
      return o;
   endfunction

   function automatic rsp_type typed_result(status_type st, logic [15:0] num,
                                            logic [7:0] src, logic [7:0] dst,
                                            logic [LEN_W-1:0] avg,
                                            logic [LEN_W-1:0] len);
      rsp_type o;
      o = '0;
      o.status = st;
      o.out_packet_number = num;
      o.out_source_address = src;
      o.out_destination_address = dst;
      o.average_length_out = avg;
      o.queue_length_out = len;
      return o;
   endfunction

   task automatic add_row(logic cmd, logic [15:0] num, logic [7:0] src, logic [7:0] dst,
                          logic typed, rsp_type want);
      plan_row_type row;
      row.req = '{cmd, num, src, dst};
      row.typed = typed;
      row.want = want;
      directed_plan.push_back(row);
   endtask

   task automatic cmp_field(string fname, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %0h got %0h", $time, fname, want, got);
      end
   endtask

   // Compare a delivered response against the oldest expectation
   task automatic check_response(rsp_type got);
      rsp_type want;
      if (pending_rsp.size() == 0) begin
         mismatches++;
         $display("%0t: response with none expected, expected nothing got %0h",
                  $time, got);
      end else begin
         want = pending_rsp.pop_front();
         cmp_field("status", 32'(want.status), 32'(got.status));
         cmp_field("out_packet_number", 32'(want.out_packet_number),
                   32'(got.out_packet_number));
         cmp_field("out_source_address", 32'(want.out_source_address),
                   32'(got.out_source_address));
         cmp_field("out_destination_address", 32'(want.out_destination_address),
                   32'(got.out_destination_address));
         cmp_field("congestion_bit", 32'(want.congestion_bit), 32'(got.congestion_bit));
         cmp_field("average_length_out", 32'(want.average_length_out),
                   32'(got.average_length_out));
         cmp_field("queue_length_out", 32'(want.queue_length_out),
                   32'(got.queue_length_out));
      end
   endtask

   // Sample both channels and the register port at the rising edge
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         ring_head = 0;
         ring_tail = 0;
         ring_count = 0;
         avg_len = 0;
         drop_thresh = int'(THRESH_RESET);
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (csr_wr_en)
            drop_thresh = int'(csr_wr_data);
         if (rsp_valid && !rsp_stall) begin
            check_response(rsp_data);
            quiet_cycles = 0;
         end
         if (req_valid && !req_stall) begin
            want = predict_queue_op(req_data);
            if (typed_has)
               want = typed_rsp;
            pending_rsp.push_back(want);
            req_accepted++;
            quiet_cycles = 0;
         end
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   // Stall the response channel at random
   always @(negedge clock) begin
      rsp_stall <= stall_on && ($urandom_range(99) < 10);
   end

   // Drive one request, idling first at random, and hold it until accepted
   task automatic send_req(req_type r, logic typed, rsp_type want);
      int seen;
      while (gaps_on && $urandom_range(99) < 10) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      typed_has <= typed;
      typed_rsp <= want;
      seen = req_accepted;
      do @(negedge clock); while (req_accepted == seen);
   endtask

   task automatic wait_drained();
      while (pending_rsp.size() != 0)
         @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   initial begin
      logic [THRESH_W-1:0] phase_thresh [8];
      req_type             r;
      logic                burst_cmd;
      int                  burst_len;
      int                  enq_pct;
      int                  sent;

      phase_thresh = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd3, 4'd5, 4'd2, 4'd7};

      // Directed part, reset threshold: empty, extremes, ring wrap, congestion drop
      add_row(CMD_DEQUEUE, 16'h1234, 8'h56, 8'h78, 1'b1,
              typed_result(ST_EMPTY, 16'h0, 8'h0, 8'h0, 4'd0, 4'd0));
      add_row(CMD_ENQUEUE, 16'hFFFF, 8'hFF, 8'hFF, 1'b1,
              typed_result(ST_QUEUED, 16'hFFFF, 8'hFF, 8'hFF, 4'd0, 4'd1));
      add_row(CMD_ENQUEUE, 16'h0000, 8'h00, 8'h00, 1'b1,
              typed_result(ST_QUEUED, 16'h0000, 8'h00, 8'h00, 4'd1, 4'd2));
      add_row(CMD_DEQUEUE, 16'h0000, 8'h00, 8'h00, 1'b1,
              typed_result(ST_DELIVERED, 16'hFFFF, 8'hFF, 8'hFF, 4'd1, 4'd1));
      add_row(CMD_DEQUEUE, 16'hFFFF, 8'hFF, 8'hFF, 1'b1,
              typed_result(ST_DELIVERED, 16'h0000, 8'h00, 8'h00, 4'd0, 4'd0));
      add_row(CMD_DEQUEUE, 16'hFFFF, 8'hFF, 8'hFF, 1'b1,
              typed_result(ST_EMPTY, 16'h0, 8'h0, 8'h0, 4'd0, 4'd0));
      for (int i = 0; i < 9; i++)
         add_row(CMD_ENQUEUE, 16'hA5A5 ^ 16'(16'h1111 * i), 8'h5A + 8'(i),
                 8'hC3 - 8'(i), 1'b0, '0);
      for (int i = 0; i < 8; i++)
         add_row(CMD_DEQUEUE, 16'(i), 8'(i), 8'(i), 1'b0, '0);

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Walk the directed table
      foreach (directed_plan[k])
         send_req(directed_plan[k].req, directed_plan[k].typed, directed_plan[k].want);
      req_valid <= 1'b0;
      typed_has <= 1'b0;

      // Random bursts, one threshold setting per phase
      foreach (phase_thresh[p]) begin
         wait_drained();
         csr_wr_en <= 1'b1;
         csr_wr_data <= phase_thresh[p];
         @(negedge clock);
         csr_wr_en <= 1'b0;
         // hold one phase with neither side idling
         gaps_on = (p != 3);
         stall_on = (p != 3);
         enq_pct = $urandom_range(40, 70);
         sent = 0;
         while (sent < PHASE_REQS) begin
            burst_cmd = ($urandom_range(99) < enq_pct) ? CMD_ENQUEUE : CMD_DEQUEUE;
            burst_len = $urandom_range(1, 10);
            repeat (burst_len) begin
               r.cmd = burst_cmd;
               r.packet_number = $urandom;
               r.source_address = $urandom;
               r.destination_address = $urandom;
               send_req(r, 1'b0, '0);
               sent++;
            end
         end
         req_valid <= 1'b0;
      end

      wait_drained();
      if (mismatches == 0 && pending_rsp.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
